>>> hdl/hctd_pkg.sv
package hctd_pkg;

    localparam int LENGTH_BITS = 32;

    localparam logic [7:0] CFG_MAX_HDR_RESET = 8'd32;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] HEX_TEN  = 8'd10;

    typedef enum logic [1:0] {
        SUB_BLANKS = 2'd0,
        SUB_ZERO   = 2'd1,
        SUB_DIGITS = 2'd2,
        SUB_IGNORE = 2'd3
    } hdr_sub_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_LONG = 2'd1,
        ERR_CR   = 2'd2,
        ERR_LF   = 2'd3
    } err_code_t;

    typedef logic [LENGTH_BITS-1:0] chunk_len_t;

    // outcome of adding one byte to the size line
    typedef struct packed {
        logic       ok;
        logic [7:0] count;
        hdr_sub_t   sub;
        chunk_len_t len;
    } line_res_t;

endpackage

>>> hdl/http_chunked_transfer_decoder_top.sv
// channel   dir  handshake                tdata            tuser / tlast
// s_*       in   s_tvalid / s_tready      data_byte[7:0]   tuser: restart
// m_*       out  m_tvalid / m_tready      payload_byte     tuser: payload_valid,
//                                                          byte_consumed, message_done,
//                                                          error_code[1:0]; tlast: chunk_last
// cfg_*     in   cfg_valid / cfg_ready    max_header_length[7:0]
//
// one byte per cycle sustained while m_tready is high: input register, one pass of parse logic, result register
// an accepted request moves from the input register into the result register, and its result
// is taken from the result register on the m_* channel
// parser state updates as the byte leaves the input register, so back-to-back bytes see it
// a stalled m_tready holds both registers; s_tready stays high while the input stage is free
// rst_n clears parser state, valid flags and sets max_header_length to 32
module http_chunked_transfer_decoder_top
    import hctd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,

    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] restart

    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] payload_byte
    output logic       m_tlast,   // chunk_last
    output logic [4:0] m_tuser    // [0] payload_valid [1] byte_consumed [2] message_done
                                  // [4:3] error_code
);

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_BODY   = 3'd1,
        PH_CR     = 3'd2,
        PH_LF     = 3'd3,
        PH_CR_END = 3'd4,
        PH_LF_END = 3'd5,
        PH_DONE   = 3'd6
    } phase_t;

    localparam chunk_len_t LEN_ONES = '1;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LO_A && c <= CH_LO_F)
            || (c >= CH_UP_A && c <= CH_UP_F);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CH_ZERO && c <= CH_NINE)
            v = c - CH_ZERO;
        else if (c >= CH_LO_A && c <= CH_LO_F)
            v = c - CH_LO_A + HEX_TEN;
        else
            v = c - CH_UP_A + HEX_TEN;
        return v[3:0];
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_LF
            || c == CH_VT || c == CH_FF;
    endfunction

    // saturates once another digit would overflow
    function automatic chunk_len_t accumulate(input chunk_len_t len, input logic [3:0] d);
        if (len[LENGTH_BITS-1 -: 4] != 4'd0)
            return LEN_ONES;
        return {len[LENGTH_BITS-5:0], d};
    endfunction

    function automatic line_res_t line_char(input logic [7:0] count, input hdr_sub_t sub,
                                            input chunk_len_t len, input logic [7:0] max_len,
                                            input logic [7:0] c);
        line_res_t r;
        logic      hx;
        logic [3:0] d;
        r.ok    = 1'b1;
        r.count = count;
        r.sub   = sub;
        r.len   = len;
        hx      = is_hex(c);
        d       = hex_val(c);
        if (count >= max_len) begin
            r.ok = 1'b0;
        end else begin
            r.count = count + 8'd1;
            case (sub)
                SUB_BLANKS: begin
                    if (is_blank(c))
                        r.sub = SUB_BLANKS;
                    else if (c == CH_ZERO)
                        r.sub = SUB_ZERO;
                    else if (hx) begin
                        r.len = accumulate(len, d);
                        r.sub = SUB_DIGITS;
                    end else
                        r.sub = SUB_IGNORE;
                end
                SUB_ZERO: begin
                    if (c == CH_LO_X || c == CH_UP_X)
                        r.sub = SUB_DIGITS;
                    else if (hx) begin
                        r.len = accumulate(len, d);
                        r.sub = SUB_DIGITS;
                    end else
                        r.sub = SUB_IGNORE;
                end
                SUB_DIGITS: begin
                    if (hx)
                        r.len = accumulate(len, d);
                    else
                        r.sub = SUB_IGNORE;
                end
                default: r.sub = sub;
            endcase
        end
        return r;
    endfunction

    logic [7:0] max_hdr_reg;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_restart_reg;

    phase_t     phase_reg, phase_next;
    chunk_len_t len_reg, len_next;
    logic [7:0] count_reg, count_next;
    hdr_sub_t   sub_reg, sub_next;
    logic       pcr_reg, pcr_next;
    err_code_t  err_reg, err_next;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_pv_reg, out_pv_next;
    logic       out_last_reg, out_last_next;
    logic       out_cons_reg, out_cons_next;
    logic       out_done_reg;

    logic       advance;
    logic       proc;
    line_res_t  lc_cr;
    line_res_t  lc_byte;

    assign advance   = !out_valid_reg || m_tready;
    assign proc      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        phase_next    = phase_reg;
        len_next      = len_reg;
        count_next    = count_reg;
        sub_next      = sub_reg;
        pcr_next      = pcr_reg;
        err_next      = err_reg;
        out_pv_next   = 1'b0;
        out_byte_next = 8'd0;
        out_last_next = 1'b0;
        out_cons_next = 1'b0;
        lc_cr         = '0;
        lc_byte       = '0;

        if (in_restart_reg) begin
            phase_next = PH_HEADER;
            len_next   = '0;
            count_next = 8'd0;
            sub_next   = SUB_BLANKS;
            pcr_next   = 1'b0;
            err_next   = ERR_NONE;
        end

        if (err_next == ERR_NONE && phase_next != PH_DONE) begin
            out_cons_next = 1'b1;
            unique case (phase_next) inside
                PH_HEADER: begin
                    if (pcr_next && in_byte_reg == CH_LF) begin
                        pcr_next   = 1'b0;
                        count_next = 8'd0;
                        sub_next   = SUB_BLANKS;
                        phase_next = (len_next == '0) ? PH_CR_END : PH_BODY;
                    end else begin
                        // a held cr that is not followed by lf counts as a line byte
                        if (pcr_next) begin
                            pcr_next = 1'b0;
                            lc_cr = line_char(count_next, sub_next, len_next, max_hdr_reg,
                                              CH_CR);
                            if (!lc_cr.ok)
                                err_next = ERR_LONG;
                            else begin
                                count_next = lc_cr.count;
                                sub_next   = lc_cr.sub;
                                len_next   = lc_cr.len;
                            end
                        end
                        if (err_next == ERR_NONE) begin
                            if (in_byte_reg == CH_CR)
                                pcr_next = 1'b1;
                            else begin
                                lc_byte = line_char(count_next, sub_next, len_next,
                                                    max_hdr_reg, in_byte_reg);
                                if (!lc_byte.ok)
                                    err_next = ERR_LONG;
                                else begin
                                    count_next = lc_byte.count;
                                    sub_next   = lc_byte.sub;
                                    len_next   = lc_byte.len;
                                end
                            end
                        end
                    end
                end
                PH_BODY: begin
                    out_pv_next   = 1'b1;
                    out_byte_next = in_byte_reg;
                    len_next      = len_next - chunk_len_t'(1);
                    if (len_next == '0) begin
                        out_last_next = 1'b1;
                        phase_next    = PH_CR;
                    end
                end
                PH_CR, PH_CR_END: begin
                    if (in_byte_reg == CH_CR)
                        phase_next = (phase_next == PH_CR) ? PH_LF : PH_LF_END;
                    else
                        err_next = ERR_CR;
                end
                PH_LF, PH_LF_END: begin
                    if (in_byte_reg == CH_LF)
                        phase_next = (phase_next == PH_LF) ? PH_HEADER : PH_DONE;
                    else
                        err_next = ERR_LF;
                end
                default: phase_next = PH_HEADER;
            endcase
            if (err_next != ERR_NONE)
                out_cons_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_hdr_reg    <= CFG_MAX_HDR_RESET;
            in_valid_reg   <= 1'b0;
            in_restart_reg <= 1'b0;
            phase_reg      <= PH_HEADER;
            len_reg        <= '0;
            count_reg      <= 8'd0;
            sub_reg        <= SUB_BLANKS;
            pcr_reg        <= 1'b0;
            err_reg        <= ERR_NONE;
            out_valid_reg  <= 1'b0;
            out_pv_reg     <= 1'b0;
            out_last_reg   <= 1'b0;
            out_cons_reg   <= 1'b0;
            out_done_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready)
                max_hdr_reg <= cfg_data;

            if (s_tvalid && s_tready) begin
                in_valid_reg   <= 1'b1;
                in_restart_reg <= s_tuser;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (proc) begin
                phase_reg    <= phase_next;
                len_reg      <= len_next;
                count_reg    <= count_next;
                sub_reg      <= sub_next;
                pcr_reg      <= pcr_next;
                err_reg      <= err_next;
                out_pv_reg   <= out_pv_next;
                out_last_reg <= out_last_next;
                out_cons_reg <= out_cons_next;
                out_done_reg <= (phase_next == PH_DONE);
            end

            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
        if (proc)
            out_byte_reg <= out_byte_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {err_reg, out_done_reg, out_cons_reg, out_pv_reg};

`ifndef SYNTHESIS
    a_last_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[0])
        else $error("chunk_last without payload");

    a_payload_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tuser[1] && m_tuser[4:3] == ERR_NONE)
        else $error("payload byte not consumed or in error");

    a_error_not_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[4:3] != ERR_NONE |-> !m_tuser[1] && !m_tuser[2])
        else $error("error result marked consumed or done");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg != ERR_NONE && !(proc && in_restart_reg) |=> err_reg == $past(err_reg))
        else $error("sticky error changed without restart");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE && !(proc && in_restart_reg) |=> phase_reg == PH_DONE)
        else $error("done phase left without restart");
`endif

endmodule
